>>> hdl/sdp100_pkg.sv
// shared constants for the power-of-100 double scaler
// power field width, step sizes and the two binary64 power-of-ten tables
// no dependencies
package sdp100_pkg;

  localparam int POWER_WIDTH = 10;
  localparam int LOW_BITS    = 4;
  localparam int BIG_STEP    = 144;

  // 1e+2 .. 1e+30, indexed by (low four bits of power) - 1
  localparam logic [63:0] SMALL_TAB [15] = '{
    $realtobits(1.0e2),  $realtobits(1.0e4),  $realtobits(1.0e6),  $realtobits(1.0e8),
    $realtobits(1.0e10), $realtobits(1.0e12), $realtobits(1.0e14), $realtobits(1.0e16),
    $realtobits(1.0e18), $realtobits(1.0e20), $realtobits(1.0e22), $realtobits(1.0e24),
    $realtobits(1.0e26), $realtobits(1.0e28), $realtobits(1.0e30)
  };

  // 1e(32*k) for k = -9 .. 9 with k = 0 left out
  localparam logic [63:0] LARGE_TAB [18] = '{
    $realtobits(1.0e-288), $realtobits(1.0e-256), $realtobits(1.0e-224),
    $realtobits(1.0e-192), $realtobits(1.0e-160), $realtobits(1.0e-128),
    $realtobits(1.0e-96),  $realtobits(1.0e-64),  $realtobits(1.0e-32),
    $realtobits(1.0e32),   $realtobits(1.0e64),   $realtobits(1.0e96),
    $realtobits(1.0e128),  $realtobits(1.0e160),  $realtobits(1.0e192),
    $realtobits(1.0e224),  $realtobits(1.0e256),  $realtobits(1.0e288)
  };

  localparam logic [4:0] LARGE_NEG_IDX = 5'd0;
  localparam logic [4:0] LARGE_POS_IDX = 5'd17;

endpackage

>>> hdl/scale_double_by_power_of_100.sv
// top level: binary64 value times 100^power as a chain of rounded multiplies
// depends on sdp100_pkg and sdp100_fmul
//
// An item is taken when start is high and busy is low. Its result appears on
// result_bits for exactly one cycle with done high; the receiver cannot hold
// it off, so it must take the item in that cycle. A zero power passes the
// operand through unchanged, with the result in the cycle after the item.
// Otherwise every step of the chain (up to five multiplies for the default
// power width) runs on one shared multiplier that, for a finite operand,
// goes through a load step, four 27x27 partial products summed into the
// accumulator, a six-step normalize search, an exponent step, a six-step
// subnormal shift and a rounding step, and that skips all of these once
// the value is zero, infinite or NaN; T_PICK picks each step's factor and
// T_WAIT waits for the multiplier. Busy stays high for the whole item.
module scale_double_by_power_of_100 (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [63:0]                            value_bits,
  input  logic signed [sdp100_pkg::POWER_WIDTH-1:0] power,
  output logic                                   done,
  output logic [63:0]                            result_bits
);

  localparam int PW = sdp100_pkg::POWER_WIDTH;
  localparam logic signed [PW-1:0] STEP = PW'(sdp100_pkg::BIG_STEP);

  typedef enum logic [1:0] {T_IDLE, T_PICK, T_WAIT} state_t;

  state_t                state;
  logic [63:0]           x;
  logic signed [PW-1:0]  p;
  logic                  low_done;
  logic                  k_done;
  logic [63:0]           cst;
  logic                  fstart;

  logic                  fdone;
  logic [63:0]           fy;

  // current power split into low digit and k = floor(p / 16)
  logic [3:0]            low;
  logic signed [PW-1:0]  k;
  logic [4:0]            kidx;

  assign busy = (state != T_IDLE);
  assign low  = p[3:0];
  assign k    = p >>> sdp100_pkg::LOW_BITS;
  assign kidx = (k < 0) ? 5'(k + PW'(9)) : 5'(k + PW'(8));

  sdp100_fmul u_fmul (
    .clk   (clk),
    .rst   (rst),
    .start (fstart),
    .a     (x),
    .b     (cst),
    .done  (fdone),
    .y     (fy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      done   <= 1'b0;
      fstart <= 1'b0;
    end else begin
      done   <= 1'b0;
      fstart <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (start) begin
            if (power == '0) begin
              // zero power: bit-exact passthrough, signaling nan included
              result_bits <= value_bits;
              done        <= 1'b1;
            end else begin
              x        <= value_bits;
              p        <= power;
              low_done <= 1'b0;
              k_done   <= 1'b0;
              state    <= T_PICK;
            end
          end
        end
        T_PICK: begin
          // pick the next factor: big steps down, big steps up, low digit, k
          if (p <= -STEP) begin
            cst    <= sdp100_pkg::LARGE_TAB[sdp100_pkg::LARGE_NEG_IDX];
            p      <= p + STEP;
            fstart <= 1'b1;
            state  <= T_WAIT;
          end else if (p >= STEP) begin
            cst    <= sdp100_pkg::LARGE_TAB[sdp100_pkg::LARGE_POS_IDX];
            p      <= p - STEP;
            fstart <= 1'b1;
            state  <= T_WAIT;
          end else if (!low_done && low != '0) begin
            cst      <= sdp100_pkg::SMALL_TAB[low - 4'd1];
            low_done <= 1'b1;
            fstart   <= 1'b1;
            state    <= T_WAIT;
          end else if (!k_done && k != '0) begin
            cst    <= sdp100_pkg::LARGE_TAB[kidx];
            k_done <= 1'b1;
            fstart <= 1'b1;
            state  <= T_WAIT;
          end else begin
            result_bits <= x;
            done        <= 1'b1;
            state       <= T_IDLE;
          end
        end
        T_WAIT: begin
          if (fdone) begin
            x     <= fy;
            state <= T_PICK;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/sdp100_fmul.sv
// multi-cycle binary64 multiplier, round to nearest even, subnormals kept
// operand b is a finite nonzero table constant; specials come from a only
// depends on nothing outside this file
module sdp100_fmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] y
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_LZ, S_EXP, S_RSH, S_RND} state_t;

  state_t              state;
  logic [2:0]          cnt;
  logic [2:0]          step;
  logic                sign;
  logic [12:0]         eexp;
  logic [52:0]         ma;
  logic [52:0]         mb;
  logic [53:0]         prod;
  logic [1:0]          pidx;
  logic [105:0]        acc;
  logic [5:0]          lz;
  logic signed [12:0]  be;
  logic [5:0]          dsh;
  logic                sticky;

  logic [26:0]         opx;
  logic [26:0]         opy;
  logic [105:0]        term;
  logic                top_zero;
  logic [105:0]        acc_lsh;
  logic [5:0]          step_amt;
  logic [105:0]        acc_rsh;
  logic                lost;
  logic                rsh_en;
  logic signed [12:0]  be_c;
  logic [5:0]          dsh_c;
  logic                ru;
  logic [53:0]         m;
  logic signed [12:0]  e;
  logic [63:0]         rnd_y;

  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        opx = ma[52:26];
        opy = mb[52:26];
      end
      2'd1: begin
        opx = ma[52:26];
        opy = {1'b0, mb[25:0]};
      end
      2'd2: begin
        opx = {1'b0, ma[25:0]};
        opy = mb[52:26];
      end
      default: begin
        opx = {1'b0, ma[25:0]};
        opy = {1'b0, mb[25:0]};
      end
    endcase
    case (pidx)
      2'd0:    term = 106'(prod) << 52;
      2'd1:    term = 106'(prod) << 26;
      2'd2:    term = 106'(prod) << 26;
      default: term = 106'(prod);
    endcase
  end

  // one step of the leading-zero search and of the subnormal right shift
  always_comb begin
    case (step)
      3'd0: begin
        step_amt = 6'd32;
        top_zero = (acc[105:74] == '0);
        acc_lsh  = acc << 32;
        acc_rsh  = acc >> 32;
        lost     = |acc[31:0];
      end
      3'd1: begin
        step_amt = 6'd16;
        top_zero = (acc[105:90] == '0);
        acc_lsh  = acc << 16;
        acc_rsh  = acc >> 16;
        lost     = |acc[15:0];
      end
      3'd2: begin
        step_amt = 6'd8;
        top_zero = (acc[105:98] == '0);
        acc_lsh  = acc << 8;
        acc_rsh  = acc >> 8;
        lost     = |acc[7:0];
      end
      3'd3: begin
        step_amt = 6'd4;
        top_zero = (acc[105:102] == '0);
        acc_lsh  = acc << 4;
        acc_rsh  = acc >> 4;
        lost     = |acc[3:0];
      end
      3'd4: begin
        step_amt = 6'd2;
        top_zero = (acc[105:104] == '0);
        acc_lsh  = acc << 2;
        acc_rsh  = acc >> 2;
        lost     = |acc[1:0];
      end
      default: begin
        step_amt = 6'd1;
        top_zero = ~acc[105];
        acc_lsh  = acc << 1;
        acc_rsh  = acc >> 1;
        lost     = acc[0];
      end
    endcase
    rsh_en = |(dsh & step_amt);
  end

  always_comb begin
    be_c = signed'(eexp) - signed'({7'b0, lz}) - 13'sd1022;
    if (be_c < -13'sd61) begin
      dsh_c = 6'd63;
    end else if (be_c < 13'sd1) begin
      dsh_c = 6'(13'sd1 - be_c);
    end else begin
      dsh_c = 6'd0;
    end
  end

  always_comb begin
    ru = acc[52] & (sticky | (|acc[51:0]) | acc[53]);
    m  = 54'(acc[105:53]) + 54'(ru);
    if (be < 13'sd1) begin
      e = 13'(m[52]);
    end else begin
      e = be + 13'(m[53]);
    end
    if (e >= 13'sd2047) begin
      rnd_y = {sign, 11'h7ff, 52'b0};
    end else if (m[53]) begin
      rnd_y = {sign, e[10:0], m[52:1]};
    end else begin
      rnd_y = {sign, e[10:0], m[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            sign <= a[63] ^ b[63];
            if (a[62:52] == 11'h7ff) begin
              // nan is quieted with payload kept, infinity takes the product sign
              y    <= (a[51:0] != '0) ? (a | (64'd1 << 51)) : {a[63] ^ b[63], a[62:0]};
              done <= 1'b1;
            end else if (a[62:0] == '0) begin
              y    <= {a[63] ^ b[63], 63'b0};
              done <= 1'b1;
            end else begin
              ma    <= {a[62:52] != '0, a[51:0]};
              mb    <= {b[62:52] != '0, b[51:0]};
              eexp  <= 13'((a[62:52] == '0) ? 11'd1 : a[62:52])
                     + 13'((b[62:52] == '0) ? 11'd1 : b[62:52]);
              acc   <= '0;
              cnt   <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // product of one pair of halves per cycle, added in the next
          if (cnt != 3'd4) begin
            prod <= 54'(opx) * 54'(opy);
            pidx <= cnt[1:0];
          end
          if (cnt != 3'd0) begin
            acc <= acc + term;
          end
          if (cnt == 3'd4) begin
            step  <= '0;
            lz    <= '0;
            state <= S_LZ;
          end
          cnt <= cnt + 3'd1;
        end
        S_LZ: begin
          if (top_zero) begin
            acc <= acc_lsh;
            lz  <= lz + step_amt;
          end
          if (step == 3'd5) begin
            state <= S_EXP;
          end
          step <= step + 3'd1;
        end
        S_EXP: begin
          be     <= be_c;
          dsh    <= dsh_c;
          sticky <= 1'b0;
          step   <= '0;
          state  <= S_RSH;
        end
        S_RSH: begin
          if (rsh_en) begin
            acc    <= acc_rsh;
            sticky <= sticky | lost;
          end
          if (step == 3'd5) begin
            state <= S_RND;
          end
          step <= step + 3'd1;
        end
        S_RND: begin
          y     <= rnd_y;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
